FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the port-level checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/feel_pkg.sv
// ---------------------------------------------------------------------------
// feel_pkg
// Types, codes and helpers of the flash EEPROM emulation log core.
// ---------------------------------------------------------------------------
`default_nettype none

package feel_pkg;

	localparam int RECORDS_MAX_DEF = 256;
	localparam int MAX_WORD_BYTES  = 8;
	localparam int INDEX_SPACE     = 2048;
	localparam int IDX_W           = 11;
	localparam int DATA_W          = 64;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 9;

	localparam logic [1:0] ACT_READ   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_FORMAT = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NODATA    = 2'd1;
	localparam logic [1:0] STAT_UNALIGNED = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WORD_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RPP        = 1'd1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ALIGN,
		S_APPEND,
		S_BUILD,
		S_SWEEP,
		S_SWAP_END,
		S_DONE
	} feel_state_t;

	function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] w);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < w) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/flash_eeprom_emulation_log_core.sv
// A read scans the records of the active page; on an empty page it does not. A write into
// a full page first runs a swap, made of the record walk and the per-index sweep of the
// position table.
// One item at a time; the next item is taken the cycle after a result is loaded.
// Reset: page zero active, both pages empty; then a clearing pass over the position
// table, during which no item is taken.
// ---------------------------------------------------------------------------
// flash_eeprom_emulation_log_core
// Two-page append-only record log emulating a word-addressed EEPROM.
// ---------------------------------------------------------------------------
`default_nettype none

module flash_eeprom_emulation_log_core #(
	parameter int RECORDS_MAX = feel_pkg::RECORDS_MAX_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           action,
	input  wire logic [feel_pkg::IDX_W-1:0]           virtual_index,
	input  wire logic [feel_pkg::DATA_W-1:0]          write_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic      [feel_pkg::DATA_W-1:0]          read_data,
	output logic      [1:0]                           status,
	output logic                                      active_page,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [feel_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [feel_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import feel_pkg::*;

	localparam int PW    = $clog2(RECORDS_MAX);
	localparam int FW    = $clog2(RECORDS_MAX + 1);
	localparam int AW    = $clog2(2 * RECORDS_MAX);
	localparam int REC_W = IDX_W + DATA_W;
	localparam int POS_W = PW + 1;

	feel_state_t state_q, state_d;

	logic [3:0]        wb_q;
	logic [8:0]        rpp_q;
	logic              act_q;
	logic [FW-1:0]     fill_q [2];
	logic [IDX_W-1:0]  idx_q;
	logic [DATA_W-1:0] data_q;
	logic [3:0]        rem_q, al_cnt_q;
	logic [PW-1:0]     k_q, k_s1;
	logic [IDX_W-1:0]  i_q, i_s1, i_s2;
	logic              iss_q, v_s1, last_s1, v_s2;
	logic              retry_q, fail_q;
	logic [DATA_W-1:0] res_data_q;
	logic [1:0]        res_st_q;
	logic              out_valid_q, out_page_q;
	logic [DATA_W-1:0] out_data_q;
	logic [1:0]        out_st_q;

	logic [3:0]        eff_w, rem_sh, rem_next;
	logic [FW-1:0]     eff_rpp;
	logic              room_act, room_to, match;

	logic              rec_we, pos_we;
	logic [AW-1:0]     rec_waddr, rec_raddr;
	logic [REC_W-1:0]  rec_wdata, rec_rdata;
	logic [IDX_W-1:0]  pos_waddr, pos_raddr;
	logic [POS_W-1:0]  pos_wdata, pos_rdata;

	function automatic logic [AW-1:0] rec_addr(input logic page, input logic [FW-1:0] k);
		return page ? AW'(RECORDS_MAX) + AW'(k) : AW'(k);
	endfunction

	feel_ram #(.WIDTH(REC_W), .DEPTH(2 * RECORDS_MAX)) u_rec (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	// newest position of each index during a swap
	feel_ram #(.WIDTH(POS_W), .DEPTH(INDEX_SPACE)) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	always_comb begin
		if (wb_q == 4'd0) begin
			eff_w = 4'd1;
		end else if (wb_q > 4'(MAX_WORD_BYTES)) begin
			eff_w = 4'(MAX_WORD_BYTES);
		end else begin
			eff_w = wb_q;
		end
		if (rpp_q < 9'd2) begin
			eff_rpp = FW'(2);
		end else if (32'(rpp_q) > 32'(RECORDS_MAX)) begin
			eff_rpp = FW'(RECORDS_MAX);
		end else begin
			eff_rpp = FW'(rpp_q);
		end
	end

	assign room_act = fill_q[act_q] < eff_rpp;
	assign room_to  = fill_q[!act_q] < eff_rpp;
	assign match    = rec_rdata[REC_W-1:DATA_W] == idx_q;

	// restoring remainder, one index bit per cycle
	assign rem_sh   = {rem_q[2:0], idx_q[al_cnt_q]};
	assign rem_next = (rem_sh >= eff_w) ? rem_sh - eff_w : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		rec_we    = 1'b0;
		rec_waddr = rec_addr(act_q, fill_q[act_q]);
		rec_wdata = {idx_q, data_q};
		rec_raddr = rec_addr(act_q, FW'(k_q));
		pos_we    = 1'b0;
		pos_waddr = i_q;
		pos_wdata = '0;
		pos_raddr = i_q;
		case (state_q)
			S_CLEAR: begin
				pos_we = 1'b1;
				if (i_q == IDX_W'(INDEX_SPACE - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (action)
						ACT_READ: state_d = (fill_q[act_q] == '0) ? S_DONE : S_SCAN;
						ACT_WRITE: state_d = S_ALIGN;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (v_s1 && (match || last_s1)) begin
					state_d = S_DONE;
				end
			end
			S_ALIGN: begin
				if (al_cnt_q == 4'd0) begin
					state_d = (rem_next != 4'd0) ? S_DONE : S_APPEND;
				end
			end
			S_APPEND: begin
				if (room_act) begin
					rec_we  = 1'b1;
					state_d = S_DONE;
				end else if (retry_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_BUILD;
				end
			end
			S_BUILD: begin
				if (v_s1) begin
					pos_we    = 1'b1;
					pos_waddr = rec_rdata[REC_W-1:DATA_W];
					pos_wdata = {1'b1, k_s1};
				end
				if (!iss_q && !v_s1) begin
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				if (v_s1) begin
					pos_we    = 1'b1;
					pos_waddr = i_s1;
				end
				rec_raddr = rec_addr(act_q, FW'(pos_rdata[PW-1:0]));
				if (v_s2 && room_to && !fail_q) begin
					rec_we    = 1'b1;
					rec_waddr = rec_addr(!act_q, fill_q[!act_q]);
					rec_wdata = {i_s2, rec_rdata[DATA_W-1:0]};
				end
				if (!iss_q && !v_s1 && !v_s2) begin
					state_d = S_SWAP_END;
				end
			end
			S_SWAP_END: begin
				state_d = fail_q ? S_DONE : S_APPEND;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q        <= 4'd4;
			rpp_q       <= 9'd256;
			act_q       <= 1'b0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			i_q         <= '0;
			iss_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			retry_q     <= 1'b0;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_WORD_BYTES: wb_q <= cfg_data[3:0];
					REG_RPP: rpp_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					i_q <= i_q + 1'b1;
				end
				S_IDLE: begin
					if (in_valid) begin
						v_s1    <= 1'b0;
						v_s2    <= 1'b0;
						retry_q <= 1'b0;
						fail_q  <= 1'b0;
						rem_q   <= '0;
						al_cnt_q <= 4'(IDX_W - 1);
						if (action == ACT_READ && fill_q[act_q] != '0) begin
							k_q   <= PW'(fill_q[act_q] - 1'b1);
							iss_q <= 1'b1;
						end
						if (action == ACT_FORMAT) begin
							fill_q[0] <= '0;
							fill_q[1] <= '0;
							act_q     <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (v_s1 && (match || last_s1)) begin
						iss_q <= 1'b0;
						v_s1  <= 1'b0;
					end else if (iss_q) begin
						v_s1    <= 1'b1;
						last_s1 <= k_q == '0;
						if (k_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							k_q <= k_q - 1'b1;
						end
					end else begin
						v_s1 <= 1'b0;
					end
				end
				S_ALIGN: begin
					rem_q    <= rem_next;
					al_cnt_q <= al_cnt_q - 1'b1;
				end
				S_APPEND: begin
					if (room_act) begin
						fill_q[act_q] <= fill_q[act_q] + 1'b1;
					end else if (!retry_q) begin
						fill_q[!act_q] <= '0;
						k_q   <= '0;
						iss_q <= 1'b1;
						v_s1  <= 1'b0;
					end
				end
				S_BUILD: begin
					if (iss_q) begin
						v_s1 <= 1'b1;
						k_s1 <= k_q;
						if (FW'(k_q) == fill_q[act_q] - 1'b1) begin
							iss_q <= 1'b0;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end else begin
						v_s1 <= 1'b0;
					end
					if (!iss_q && !v_s1) begin
						i_q   <= '0;
						iss_q <= 1'b1;
						v_s2  <= 1'b0;
					end
				end
				S_SWEEP: begin
					if (iss_q) begin
						v_s1 <= 1'b1;
						i_s1 <= i_q;
						if (i_q == IDX_W'(INDEX_SPACE - 1)) begin
							iss_q <= 1'b0;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						v_s1 <= 1'b0;
					end
					v_s2 <= v_s1 && pos_rdata[PW];
					i_s2 <= i_s1;
					if (v_s2) begin
						if (room_to && !fail_q) begin
							fill_q[!act_q] <= fill_q[!act_q] + 1'b1;
						end else begin
							fail_q <= 1'b1;
						end
					end
				end
				S_SWAP_END: begin
					if (fail_q) begin
						fill_q[!act_q] <= '0;
					end else begin
						fill_q[act_q] <= '0;
						act_q   <= !act_q;
						retry_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					idx_q      <= virtual_index;
					data_q     <= write_data & byte_mask(eff_w);
					res_data_q <= '0;
					res_st_q   <= (action == ACT_READ && fill_q[act_q] == '0) ?
						STAT_NODATA : STAT_OK;
				end
			end
			S_SCAN: begin
				if (v_s1) begin
					if (match) begin
						res_data_q <= rec_rdata[DATA_W-1:0] & byte_mask(eff_w);
					end else if (last_s1) begin
						res_st_q <= STAT_NODATA;
					end
				end
			end
			S_ALIGN: begin
				if (al_cnt_q == 4'd0 && rem_next != 4'd0) begin
					res_st_q <= STAT_UNALIGNED;
				end
			end
			S_APPEND: begin
				if (!room_act && retry_q) begin
					res_st_q <= STAT_FULL;
				end
			end
			S_SWAP_END: begin
				if (fail_q) begin
					res_st_q <= STAT_FULL;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_data_q <= res_data_q;
					out_st_q   <= res_st_q;
					out_page_q <= act_q;
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign read_data   = out_data_q;
	assign status      = out_st_q;
	assign active_page = out_page_q;

endmodule

`default_nettype wire

FILE: hw/rtl/feel_ram.sv
// ---------------------------------------------------------------------------
// feel_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module feel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/feel_chk.sv
// ---------------------------------------------------------------------------
// feel_chk
// Port-level checks of the emulation log core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module feel_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic [1:0]                      action,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire logic [feel_pkg::DATA_W-1:0]     read_data,
	input wire logic [1:0]                      status
);

	import feel_pkg::*;

	// a stalled word holds
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(read_data) && $stable(status))

	// only a good read carries data
	`ASSERT_IMP(a_zero_data, clk, arst_n, out_valid && status != STAT_OK, read_data == '0)

	// one word in flight: busy right after taking one
	`ASSERT_NXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)

	// after a format the core is busy and no fresh word shows yet
	`ASSERT_NXT(a_fmt, clk, arst_n, in_valid && !in_stall && action == ACT_FORMAT,
		in_stall && !out_valid || (out_valid && $past(out_stall)))

endmodule

bind flash_eeprom_emulation_log_core feel_chk u_feel_chk (.*);

`default_nettype wire
